// File: design/sfr_pkg.sv
// sfr_pkg: shared types and constants for the sensor frame receiver.
// Used by sfr_decode and sensor_frame_receiver; depends on nothing.

package sfr_pkg;

    localparam int ByteW = 8;
    localparam int CfgIdxW = 2;

    typedef logic [ByteW-1:0] byte_t;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_HEADER    = 2'd0,
        CFG_COMMAND   = 2'd1,
        CFG_THRESHOLD = 2'd2
    } cfg_idx_t;

    localparam byte_t HeaderReset    = 8'hA1;
    localparam byte_t CommandReset   = 8'h5A;
    localparam byte_t ThresholdReset = 8'h10;

    localparam byte_t KindWeight = 8'h00;
    localparam byte_t KindCalib  = 8'h0F;
    localparam byte_t CalibTag   = 8'hCA;
    localparam byte_t CalibOk    = 8'hFF;
    localparam byte_t CalibZero  = 8'h3A;
    localparam byte_t CalibFail  = 8'h24;

    typedef enum logic [1:0] {
        CAL_NONE = 2'd0,
        CAL_OK   = 2'd1,
        CAL_ZERO = 2'd2,
        CAL_FAIL = 2'd3
    } calib_t;

    typedef struct packed {
        logic   checksum_ok;
        byte_t  kind_byte;
        byte_t  payload_one;
        byte_t  payload_two;
        logic   alarm_update;
        logic   alarm_level;
        calib_t calib_event;
    } result_t;

endpackage

// File: design/sfr_decode.sv
// sfr_decode: checksum check and payload decode for one finished frame.
// Pure combinational; uses sfr_pkg types and constants.

module sfr_decode (
    input  sfr_pkg::byte_t   sum_total,
    input  sfr_pkg::byte_t   kind_byte,
    input  sfr_pkg::byte_t   payload_one,
    input  sfr_pkg::byte_t   payload_two,
    input  sfr_pkg::byte_t   alarm_threshold,
    output sfr_pkg::result_t result
);

    logic ok;

    // checksum byte is the negated sum, so the total wraps to zero on a match
    assign ok = (sum_total == '0);

    always_comb
    begin
        result              = '0;
        result.checksum_ok  = ok;
        result.kind_byte    = kind_byte;
        result.payload_one  = payload_one;
        result.payload_two  = payload_two;
        result.alarm_update = 1'b0;
        result.alarm_level  = 1'b0;
        result.calib_event  = sfr_pkg::CAL_NONE;
        if (ok)
        begin
            if (kind_byte == sfr_pkg::KindWeight)
            begin
                result.alarm_update = 1'b1;
                result.alarm_level  = (payload_one > alarm_threshold);
            end
            else if (kind_byte == sfr_pkg::KindCalib && payload_one == sfr_pkg::CalibTag)
            begin
                case (payload_two)
                    sfr_pkg::CalibOk:   result.calib_event = sfr_pkg::CAL_OK;
                    sfr_pkg::CalibZero: result.calib_event = sfr_pkg::CAL_ZERO;
                    sfr_pkg::CalibFail: result.calib_event = sfr_pkg::CAL_FAIL;
                    default:            result.calib_event = sfr_pkg::CAL_NONE;
                endcase
            end
        end
    end

endmodule

// File: design/sensor_frame_receiver.sv
// sensor_frame_receiver: top level of the serial frame parser.
// Depends on sfr_pkg and sfr_decode.
//
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) takes one received byte per item.
//   A frame is header, command, three payload bytes and a checksum byte.
//   Only the checksum byte produces a result item on the output channel
//   (out_valid/out_ready); all other bytes are absorbed by the parser.
//   The result is registered and appears in the cycle after the checksum byte is taken.
//   Throughput: one byte per cycle, sustained, unless a checksum byte waits on a full output.
//   The output register holds a result until it is taken; while it is full
//   and stalled, non-checksum bytes are still taken, and a checksum byte
//   waits until out_ready frees the register (in the same cycle if high).
//   Config port: cfg_we with cfg_index/cfg_data writes header, command or
//   alarm threshold; an unknown index is ignored. Write only when idle.
//   Reset: parser hunts for a header, sum cleared, registers to defaults,
//   output empty.

module sensor_frame_receiver (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sfr_pkg::CfgIdxW-1:0]   cfg_index,
    input  sfr_pkg::byte_t                cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  sfr_pkg::byte_t                rx_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          checksum_ok,
    output sfr_pkg::byte_t                kind_byte,
    output sfr_pkg::byte_t                payload_one,
    output sfr_pkg::byte_t                payload_two,
    output logic                          alarm_update,
    output logic                          alarm_level,
    output logic [1:0]                    calib_event
);

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_CMD  = 3'd1,
        PH_P0   = 3'd2,
        PH_P1   = 3'd3,
        PH_P2   = 3'd4,
        PH_CHK  = 3'd5
    } phase_t;

    phase_t            phase_reg, phase_next;
    sfr_pkg::byte_t    sum_reg, sum_next;
    sfr_pkg::byte_t    header_reg, command_reg, threshold_reg;
    sfr_pkg::byte_t    p0_reg, p1_reg, p2_reg;
    logic              out_valid_reg, out_valid_next;
    sfr_pkg::result_t  result_reg, result_next;
    sfr_pkg::result_t  decoded;
    logic              in_fire;
    sfr_pkg::byte_t    sum_total;

    assign in_ready  = (phase_reg != PH_CHK) || !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign sum_total = sum_reg + rx_byte;

    sfr_decode u_decode (
        .sum_total       (sum_total),
        .kind_byte       (p0_reg),
        .payload_one     (p1_reg),
        .payload_two     (p2_reg),
        .alarm_threshold (threshold_reg),
        .result          (decoded)
    );

    always_comb
    begin
        phase_next     = phase_reg;
        sum_next       = sum_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (in_fire)
        begin
            case (phase_reg)
                PH_HUNT: phase_next = (rx_byte == header_reg) ? PH_CMD : PH_HUNT;
                PH_CMD:
                begin
                    if (rx_byte == command_reg)
                    begin
                        sum_next   = rx_byte;
                        phase_next = PH_P0;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_P0:
                begin
                    sum_next   = sum_total;
                    phase_next = PH_P1;
                end
                PH_P1:
                begin
                    sum_next   = sum_total;
                    phase_next = PH_P2;
                end
                PH_P2:
                begin
                    sum_next   = sum_total;
                    phase_next = PH_CHK;
                end
                PH_CHK:
                begin
                    result_next    = decoded;
                    out_valid_next = 1'b1;
                    phase_next     = PH_HUNT;
                end
                default: phase_next = PH_HUNT;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            header_reg    <= sfr_pkg::HeaderReset;
            command_reg   <= sfr_pkg::CommandReset;
            threshold_reg <= sfr_pkg::ThresholdReset;
        end
        else
        begin
            phase_reg     <= phase_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    sfr_pkg::CFG_HEADER:    header_reg    <= cfg_data;
                    sfr_pkg::CFG_COMMAND:   command_reg   <= cfg_data;
                    sfr_pkg::CFG_THRESHOLD: threshold_reg <= cfg_data;
                    default:                ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (in_fire)
        begin
            case (phase_reg)
                PH_P0:   p0_reg <= rx_byte;
                PH_P1:   p1_reg <= rx_byte;
                PH_P2:   p2_reg <= rx_byte;
                default: ;
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign checksum_ok  = result_reg.checksum_ok;
    assign kind_byte    = result_reg.kind_byte;
    assign payload_one  = result_reg.payload_one;
    assign payload_two  = result_reg.payload_two;
    assign alarm_update = result_reg.alarm_update;
    assign alarm_level  = result_reg.alarm_level;
    assign calib_event  = result_reg.calib_event;

`ifndef SYNTH
    a_chk_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && phase_reg == PH_CHK |=> out_valid_reg && phase_reg == PH_HUNT)
        else $error("checksum byte did not produce a result");

    a_bad_sum_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_reg.checksum_ok |->
            !result_reg.alarm_update && result_reg.calib_event == sfr_pkg::CAL_NONE)
        else $error("decode flags set on checksum mismatch");

    a_level_needs_update: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_reg.alarm_update |-> !result_reg.alarm_level)
        else $error("alarm level without update");

    a_update_xor_calib: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.alarm_update |->
            result_reg.calib_event == sfr_pkg::CAL_NONE)
        else $error("weight report and calibration event together");

    a_hunt_step: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && phase_reg == PH_HUNT |=> phase_reg == PH_HUNT || phase_reg == PH_CMD)
        else $error("illegal step out of hunting");
`endif

endmodule

// File: tb/tb.sv
// tb: self-checking bench for sensor_frame_receiver (serial weight-sensor frame parser).
// Depends on sfr_pkg and the sensor_frame_receiver RTL; drives random and directed
// byte streams, tracks the parser in a local frame decoder and checks each report.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfr_pkg::*;

    typedef enum logic [2:0] {
        P_HUNT,
        P_CMD,
        P_KIND,
        P_ONE,
        P_TWO,
        P_SUM
    } parse_t;

    localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
    localparam int CycleLimit = 200000;
    localparam int HoldOffCycles = 300;
    localparam int PhaseBytes = 170;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CfgIdxW-1:0] cfg_index = '0;
    byte_t cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    byte_t rx_byte = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic checksum_ok;
    byte_t kind_byte;
    byte_t payload_one;
    byte_t payload_two;
    logic alarm_update;
    logic alarm_level;
    logic [1:0] calib_event;

    // local copy of the parser and its registers
    byte_t hdr_cfg = HeaderReset;
    byte_t cmd_cfg = CommandReset;
    byte_t thr_cfg = ThresholdReset;
    parse_t parse_state = P_HUNT;
    byte_t sum_acc = '0;
    byte_t kind_q = '0;
    byte_t one_q = '0;
    byte_t two_q = '0;
    result_t frame_reports_due[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    int mismatch_count = 0;
    int unsigned cycle_count = 0;

    sensor_frame_receiver dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .checksum_ok  (checksum_ok),
        .kind_byte    (kind_byte),
        .payload_one  (payload_one),
        .payload_two  (payload_two),
        .alarm_update (alarm_update),
        .alarm_level  (alarm_level),
        .calib_event  (calib_event)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // receiver: random stalls, or a counted hold-off when requested
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic parse_rx_byte(input byte_t b);
        result_t r;
        case (parse_state)
            P_HUNT:
                if (b == hdr_cfg)
                    parse_state = P_CMD;
            P_CMD:
                if (b == cmd_cfg)
                begin
                    sum_acc = b;
                    parse_state = P_KIND;
                end
                else
                begin
                    parse_state = P_HUNT;
                end
            P_KIND:
            begin
                kind_q = b;
                sum_acc = sum_acc + b;
                parse_state = P_ONE;
            end
            P_ONE:
            begin
                one_q = b;
                sum_acc = sum_acc + b;
                parse_state = P_TWO;
            end
            P_TWO:
            begin
                two_q = b;
                sum_acc = sum_acc + b;
                parse_state = P_SUM;
            end
            P_SUM:
            begin
                r = '0;
                r.calib_event = CAL_NONE;
                // frame is good when command + payload + checksum wraps to zero
                r.checksum_ok = (byte_t'(sum_acc + b) == 8'h00);
                r.kind_byte = kind_q;
                r.payload_one = one_q;
                r.payload_two = two_q;
                if (r.checksum_ok)
                begin
                    if (kind_q == KindWeight)
                    begin
                        r.alarm_update = 1'b1;
                        r.alarm_level = (one_q > thr_cfg);
                    end
                    else if (kind_q == KindCalib && one_q == CalibTag)
                    begin
                        case (two_q)
                            CalibOk:   r.calib_event = CAL_OK;
                            CalibZero: r.calib_event = CAL_ZERO;
                            CalibFail: r.calib_event = CAL_FAIL;
                            default:   r.calib_event = CAL_NONE;
                        endcase
                    end
                end
                frame_reports_due.push_back(r);
                parse_state = P_HUNT;
            end
            default:
                parse_state = P_HUNT;
        endcase
    endtask

    task automatic compare_field(input string field, input int want, input int got);
        if (want != got)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch %s: expected %0h got %0h at cycle %0d",
                         field, want, got, cycle_count);
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (frame_reports_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected frame report at cycle %0d", cycle_count);
            end
            else
            begin
                want = frame_reports_due.pop_front();
                compare_field("checksum_ok", want.checksum_ok, checksum_ok);
                compare_field("kind_byte", want.kind_byte, kind_byte);
                compare_field("payload_one", want.payload_one, payload_one);
                compare_field("payload_two", want.payload_two, payload_two);
                compare_field("alarm_update", want.alarm_update, alarm_update);
                compare_field("alarm_level", want.alarm_level, alarm_level);
                compare_field("calib_event", int'(want.calib_event), int'(calib_event));
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_byte(input byte_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        parse_rx_byte(b);
        @(negedge clk);
    endtask

    task automatic send_frame(input byte_t kind, input byte_t one, input byte_t two,
                              input bit corrupt);
        byte_t sum;
        byte_t chk;
        sum = cmd_cfg + kind + one + two;
        chk = 8'h00 - sum;
        if (corrupt)
            chk = chk + byte_t'($urandom_range(1, 255));
        send_byte(hdr_cfg);
        send_byte(cmd_cfg);
        send_byte(kind);
        send_byte(one);
        send_byte(two);
        send_byte(chk);
    endtask

    function automatic void pick_payload(output byte_t kind, output byte_t one,
                                         output byte_t two);
        int pick;
        pick = $urandom_range(99);
        kind = byte_t'($urandom);
        one = byte_t'($urandom);
        two = byte_t'($urandom);
        if (pick < 40)
        begin
            kind = KindWeight;
            case ($urandom_range(3))
                0: one = thr_cfg;
                1: one = thr_cfg + 8'd1;
                2: one = thr_cfg - 8'd1;
                default: ;
            endcase
        end
        else if (pick < 75)
        begin
            kind = KindCalib;
            if ($urandom_range(99) < 80)
                one = CalibTag;
            case ($urandom_range(3))
                0: two = CalibOk;
                1: two = CalibZero;
                2: two = CalibFail;
                default: ;
            endcase
        end
    endfunction

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (frame_reports_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input byte_t val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        case (idx)
            CFG_HEADER:    hdr_cfg = val;
            CFG_COMMAND:   cmd_cfg = val;
            CFG_THRESHOLD: thr_cfg = val;
            default: ;
        endcase
    endtask

    task automatic configure(input byte_t hdr, input byte_t cmd, input byte_t thr);
        wait_idle();
        write_reg(CFG_HEADER, hdr);
        write_reg(CFG_COMMAND, cmd);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CfgUnused, byte_t'($urandom));
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic random_traffic(input int byte_goal);
        int sent;
        int pick;
        int cut;
        byte_t kind;
        byte_t one;
        byte_t two;
        sent = 0;
        while (sent < byte_goal)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
            begin
                pick_payload(kind, one, two);
                send_frame(kind, one, two, $urandom_range(99) < 15);
                sent += 6;
            end
            else if (pick < 88)
            begin
                // header followed by a wrong command
                send_byte(hdr_cfg);
                send_byte(cmd_cfg ^ byte_t'($urandom_range(1, 255)));
                sent += 2;
            end
            else if (pick < 93)
            begin
                // truncated frame; the next bytes complete it
                cut = $urandom_range(1, 3);
                send_byte(hdr_cfg);
                send_byte(cmd_cfg);
                repeat (cut) send_byte(byte_t'($urandom));
                sent += 2 + cut;
            end
            else
            begin
                repeat ($urandom_range(1, 4)) send_byte(byte_t'($urandom));
            end
        end
    endtask

    task automatic test_reset_defaults();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_byte(8'h00);
        send_byte(hdr_cfg);
        send_byte(~cmd_cfg);
        send_frame(KindWeight, 8'hFF, 8'h00, 1'b0);
        send_frame(KindWeight, ThresholdReset, 8'hFF, 1'b0);
        send_frame(KindCalib, CalibTag, CalibOk, 1'b0);
        send_frame(KindCalib, CalibTag, CalibFail, 1'b1);
    endtask

    task automatic test_extreme_registers();
        configure(8'h00, 8'hFF, 8'h00);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_traffic(PhaseBytes);
    endtask

    task automatic test_inverted_registers();
        configure(8'hFF, 8'h00, 8'hFF);
        send_idle_pct = 61;
        recv_stall_pct = 0;
        random_traffic(PhaseBytes);
    endtask

    task automatic test_random_registers_stall();
        configure(byte_t'($urandom), byte_t'($urandom), byte_t'($urandom));
        send_idle_pct = 0;
        recv_stall_pct = 61;
        random_traffic(PhaseBytes);
    endtask

    task automatic test_random_registers_mixed();
        configure(byte_t'($urandom), byte_t'($urandom), byte_t'($urandom));
        send_idle_pct = 32;
        recv_stall_pct = 32;
        random_traffic(PhaseBytes);
    endtask

    // long receiver hold-off while frames keep coming, so the input stalls
    task automatic test_output_hold_off();
        byte_t kind;
        byte_t one;
        byte_t two;
        wait_idle();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = HoldOffCycles;
        repeat (6)
        begin
            pick_payload(kind, one, two);
            send_frame(kind, one, two, 1'b0);
        end
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_defaults();
        test_extreme_registers();
        test_inverted_registers();
        test_random_registers_stall();
        test_random_registers_mixed();
        test_output_hold_off();
        wait_idle();
        mismatch_count += frame_reports_due.size();
        if (mismatch_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
